// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the mailbox checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SGRM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SGRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/sgrm_pkg.sv
// ----------------------------------------------------------------------------
// sgrm_pkg
// Types, codes and default sizes shared by the ring mailbox modules.
// ----------------------------------------------------------------------------
package sgrm_pkg;

  localparam int RING_DEPTH_DEFAULT = 256;
  localparam int SEM_COUNT_DEFAULT  = 16;

  localparam int SEM_IDX_W  = 4;
  localparam int CAP_LOG2_W = 4;
  localparam int LINE_W     = 5;
  localparam int WORD_W     = 32;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_CAP_LOG2    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_SEM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_CHAN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_LINE = 2'd3;

  typedef enum logic [2:0] {
    CMD_PRODUCE = 3'd0,
    CMD_CONSUME = 3'd1,
    CMD_TAKE    = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_PROBE   = 3'd4,
    CMD_INIT    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BUSY    = 2'd1,
    STAT_NO_DATA = 2'd2
  } status_t;

  typedef struct packed {
    logic                 valid;
    cmd_t                 cmd;
    logic [SEM_IDX_W-1:0] sidx;
    logic [SEM_IDX_W-1:0] guard;
  } sem_req_t;

  typedef struct packed {
    logic sel_locked;
    logic guard_locked;
  } sem_stat_t;

endpackage

// File: design/sgrm_ring_mem.sv
// ----------------------------------------------------------------------------
// sgrm_ring_mem
// Single-port-write, single-port-read slot memory with registered read data.
// ----------------------------------------------------------------------------
module sgrm_ring_mem import sgrm_pkg::*; #(
  parameter int DEPTH = RING_DEPTH_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data only moves on a read, so it holds while the result waits.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/sgrm_sem_bank.sv
// ----------------------------------------------------------------------------
// sgrm_sem_bank
// Bank of hardware semaphores with take, release and probe.
// ----------------------------------------------------------------------------
module sgrm_sem_bank import sgrm_pkg::*; #(
  parameter int SEM_COUNT = SEM_COUNT_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  sem_req_t  req,
  output sem_stat_t stat
);

  // Only semaphores reachable by a 4-bit index get storage.
  localparam int IDX_SPAN = 1 << SEM_IDX_W;
  localparam int LOCK_W   = (SEM_COUNT < IDX_SPAN) ? SEM_COUNT : IDX_SPAN;

  logic [LOCK_W-1:0]   lock_bits;
  logic [LOCK_W-1:0]   lock_bits_next;
  logic [IDX_SPAN-1:0] lock_view;

  // A semaphore that does not exist reads as permanently locked.
  for (genvar i = 0; i < IDX_SPAN; i++) begin : g_view
    if (i < LOCK_W) begin : g_real
      assign lock_view[i] = lock_bits[i];
    end else begin : g_missing
      assign lock_view[i] = 1'b1;
    end
  end

  assign stat.sel_locked   = lock_view[req.sidx];
  assign stat.guard_locked = lock_view[req.guard];

  always_comb begin
    lock_bits_next = lock_bits;
    for (int i = 0; i < LOCK_W; i++) begin
      if (req.valid && req.sidx == SEM_IDX_W'(i)) begin
        if (req.cmd == CMD_TAKE) begin
          lock_bits_next[i] = 1'b1;
        end else if (req.cmd == CMD_RELEASE) begin
          lock_bits_next[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_bits <= '0;
    end else begin
      lock_bits <= lock_bits_next;
    end
  end

endmodule

// File: design/semaphore_guarded_ring_mailbox_top.sv
// ----------------------------------------------------------------------------
// semaphore_guarded_ring_mailbox_top
// Inter-core mailbox: semaphore bank plus a guarded power-of-two word ring.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the input channel (in_valid / in_stall) as one beat of
// cmd, sem_index and data_in. Each command yields exactly one result beat on
// the output channel (out_valid / out_stall), in command order.
// The result of a command is registered and shown from the cycle after
// it is accepted. Throughput is one command per cycle while the receiver
// does not stall, set by the single write port and single registered read
// port of the slot memory; a produce writes its slot and a consume reads its
// slot in the same cycle the command is accepted.
// The result sits in an output register. While the receiver stalls, that
// register and the memory read data hold, and in_stall is raised; a new
// command is taken in the same cycle the waiting result is taken.
// Reset clears both ring counters, frees every semaphore, loads the
// configuration defaults and empties the output register. The slot memory is
// not cleared; its read data reaches data_out only for a successful consume.
// Configuration is written through cfg_wen / cfg_index / cfg_data while no
// command is in flight.
// ----------------------------------------------------------------------------
module semaphore_guarded_ring_mailbox_top import sgrm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT,
  parameter int SEM_COUNT  = SEM_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // command channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            cmd,
  input  logic [SEM_IDX_W-1:0]  sem_index,
  input  logic [WORD_W-1:0]     data_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [WORD_W-1:0]     data_out,
  output logic                  was_locked,
  output logic                  notify_fire,
  output logic                  notify_chan_out,
  output logic [LINE_W-1:0]     notify_line_out,
  output logic                  ring_empty,
  output logic                  ring_full
);

  localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  // Largest exponent whose power of two still fits in the memory.
  localparam int DEPTH_LOG2 = $clog2(RING_DEPTH + 1) - 1;
  localparam int K_W        = CAP_LOG2_W + 1;

  // Configuration registers.
  logic [CAP_LOG2_W-1:0] cap_log2;
  logic [SEM_IDX_W-1:0]  guard_sem;
  logic                  notify_chan;
  logic [LINE_W-1:0]     notify_line;

  // Free-running ring counters; the fill level is their difference.
  logic [WORD_W-1:0] wc;
  logic [WORD_W-1:0] rc;
  logic [WORD_W-1:0] wc_next;
  logic [WORD_W-1:0] rc_next;

  // Output register.
  logic              out_valid_q;
  status_t           status_q;
  logic              was_q;
  logic              fire_q;
  logic              chan_q;
  logic [LINE_W-1:0] line_q;
  logic              empty_q;
  logic              full_q;
  logic              rd_sel_q;

  logic              accept;
  cmd_t              cmd_c;
  logic [K_W-1:0]    eff_k;
  logic [WORD_W-1:0] cap;
  logic [ADDR_W-1:0] mask;
  logic [WORD_W-1:0] level;
  logic [WORD_W-1:0] level_next;
  status_t           status_next;
  logic              was_next;
  logic              fire_next;
  logic              rd_ok;
  logic              mem_we;
  logic [WORD_W-1:0] mem_rdata;
  sem_req_t          sem_req;
  sem_stat_t         sem_stat;

  assign in_stall = out_valid_q & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Effective capacity saturates at the largest power of two that fits in the memory.
  always_comb begin
    if ({1'b0, cap_log2} > K_W'(DEPTH_LOG2)) begin
      eff_k = K_W'(DEPTH_LOG2);
    end else begin
      eff_k = {1'b0, cap_log2};
    end
  end

  assign cap  = WORD_W'(1) << eff_k;
  assign mask = ADDR_W'(cap - WORD_W'(1));

  assign sem_req.valid = accept;
  assign sem_req.cmd   = cmd_c;
  assign sem_req.sidx  = sem_index;
  assign sem_req.guard = guard_sem;

  sgrm_sem_bank #(
    .SEM_COUNT (SEM_COUNT)
  ) u_sem (
    .clk  (clk),
    .rst  (rst),
    .req  (sem_req),
    .stat (sem_stat)
  );

  // Command decode. Lock updates happen in the semaphore bank; this block
  // decides the answer and moves the ring counters.
  always_comb begin
    cmd_c       = cmd_t'(cmd);
    level       = wc - rc;
    wc_next     = wc;
    rc_next     = rc;
    status_next = STAT_OK;
    was_next    = 1'b0;
    fire_next   = 1'b0;
    rd_ok       = 1'b0;
    mem_we      = 1'b0;
    case (cmd_c)
      CMD_PRODUCE: begin
        if (sem_stat.guard_locked || level >= cap) begin
          status_next = STAT_BUSY;
        end else begin
          mem_we    = 1'b1;
          wc_next   = wc + WORD_W'(1);
          fire_next = 1'b1;
        end
      end
      CMD_CONSUME: begin
        if (sem_stat.guard_locked) begin
          status_next = STAT_BUSY;
        end else if (level == '0) begin
          status_next = STAT_NO_DATA;
        end else begin
          rd_ok   = 1'b1;
          rc_next = rc + WORD_W'(1);
        end
      end
      CMD_TAKE: begin
        was_next = sem_stat.sel_locked;
        if (sem_stat.sel_locked) begin
          status_next = STAT_BUSY;
        end
      end
      CMD_PROBE: begin
        was_next = sem_stat.sel_locked;
      end
      CMD_INIT: begin
        wc_next = '0;
        rc_next = '0;
      end
      default: begin
        // Release answers ok; unknown codes change nothing.
      end
    endcase
    level_next = wc_next - rc_next;
  end

  // The read is issued on every accepted command so that the read data is
  // held with the rest of the result while the receiver stalls.
  sgrm_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (accept & mem_we),
    .waddr (wc[ADDR_W-1:0] & mask),
    .wdata (data_in),
    .re    (accept),
    .raddr (rc[ADDR_W-1:0] & mask),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2    <= CAP_LOG2_RESET;
      guard_sem   <= '0;
      notify_chan <= 1'b0;
      notify_line <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_CAP_LOG2:    cap_log2    <= cfg_data[CAP_LOG2_W-1:0];
        CFG_GUARD_SEM:   guard_sem   <= cfg_data[SEM_IDX_W-1:0];
        CFG_NOTIFY_CHAN: notify_chan <= cfg_data[0];
        CFG_NOTIFY_LINE: notify_line <= cfg_data[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc          <= '0;
      rc          <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wc          <= wc_next;
        rc          <= rc_next;
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      was_q    <= was_next;
      fire_q   <= fire_next;
      chan_q   <= fire_next & notify_chan;
      line_q   <= fire_next ? notify_line : '0;
      empty_q  <= (level_next == '0);
      full_q   <= (level_next >= cap);
      rd_sel_q <= rd_ok;
    end
  end

  assign out_valid       = out_valid_q;
  assign status          = status_q;
  assign data_out        = rd_sel_q ? mem_rdata : '0;
  assign was_locked      = was_q;
  assign notify_fire     = fire_q;
  assign notify_chan_out = chan_q;
  assign notify_line_out = line_q;
  assign ring_empty      = empty_q;
  assign ring_full       = full_q;

endmodule

// File: design/sgrm_checker.sv
// ----------------------------------------------------------------------------
// sgrm_checker
// Port-level checks of the ring mailbox, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgrm_checker import sgrm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic [WORD_W-1:0] data_out,
  input logic              notify_fire,
  input logic              ring_empty,
  input logic              ring_full
);

  // A waiting result must not change under a stall.
  `SGRM_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(status), "stalled result changed")

  // Every accepted command shows its result on the next cycle.
  `SGRM_ASSERT(a_latency, clk, rst, in_valid && !in_stall |=> out_valid, "result missing after accept")

  // A notification only comes from a successful produce, which leaves a word.
  `SGRM_ASSERT(a_notify, clk, rst, out_valid && notify_fire |-> status == STAT_OK && data_out == '0 && !ring_empty, "bad notification")

  // No data means the ring is empty and nothing was read.
  `SGRM_ASSERT(a_no_data, clk, rst, out_valid && status == STAT_NO_DATA |-> ring_empty && data_out == '0 && !notify_fire, "bad no-data result")

  // Capacity is at least one, so the ring is never empty and full at once.
  `SGRM_ASSERT(a_flags, clk, rst, out_valid |-> !(ring_empty && ring_full), "ring both empty and full")

endmodule

bind semaphore_guarded_ring_mailbox_top sgrm_checker u_sgrm_checker (.*);
